### rtl/sparse_triplet_transpose_unit_macros.svh
// Assertion macros for the sparse triplet transpose unit.
// Included by the RTL files that carry concurrent assertions; needs no other file.
`ifndef SPARSE_TRIPLET_TRANSPOSE_UNIT_MACROS_SVH
`define SPARSE_TRIPLET_TRANSPOSE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is held.
`define STT_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define STT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define STT_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons, msg)
`define STT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/stt_pkg.sv
// Shared types and constants of the sparse triplet transpose unit.
// Has no dependencies; the other RTL modules and interfaces refer to it by scoped names.
`timescale 1ns / 1ps

package stt_pkg;

  localparam int DIM_W = 9;
  localparam int IDX_W = 8;
  localparam int VAL_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int unsigned MAX_DIM = 256;

  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_COLS = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CNT_RD,
    ST_CNT_CHK,
    ST_HDR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_PASS_END
  } state_t;

  // One stored term, packed as row, column, value.
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } term_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] word_col;
    logic [IDX_W-1:0] cur_col;
    logic [IDX_W-1:0] nxt_col;
    logic             nxt_found;
    logic             scan_mode;
    logic [DIM_W-1:0] matrix_cols;
  } cmp_req_t;

  typedef struct packed {
    logic col_ok;
    logic match;
    logic better;
  } cmp_res_t;

endpackage

### rtl/stt_if.sv
// Valid/ready channel interfaces for input terms and transposed results.
// Depends on stt_pkg for field widths.
`timescale 1ns / 1ps

interface stt_in_if;
  logic                        valid;
  logic                        ready;
  logic [stt_pkg::IDX_W-1:0]   term_row;
  logic [stt_pkg::IDX_W-1:0]   term_col;
  logic signed [stt_pkg::VAL_W-1:0] term_value;
  logic                        has_term;
  logic                        last_term;

  modport source (output valid, term_row, term_col, term_value, has_term, last_term,
                  input ready);
  modport sink (input valid, term_row, term_col, term_value, has_term, last_term,
                output ready);
endinterface

interface stt_out_if;
  logic                        valid;
  logic                        ready;
  logic [stt_pkg::DIM_W-1:0]   out_row;
  logic [stt_pkg::DIM_W-1:0]   out_col;
  logic signed [stt_pkg::VAL_W-1:0] out_value;
  logic                        is_header;
  logic                        last_result;

  modport source (output valid, out_row, out_col, out_value, is_header, last_result,
                  input ready);
  modport sink (input valid, out_row, out_col, out_value, is_header, last_result,
                output ready);
endinterface

### rtl/stt_term_mem.sv
// Term store: one write port, one read port with registered read data.
// Depends on stt_pkg for the stored word type.
`timescale 1ns / 1ps

module stt_term_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  stt_pkg::term_word_t wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output stt_pkg::term_word_t rdata
);

  stt_pkg::term_word_t mem [DEPTH];
  stt_pkg::term_word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/stt_col_cmp.sv
// Shared column compare unit: range check, current-column match and
// next-column candidate search. Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_col_cmp (
  input  stt_pkg::cmp_req_t req,
  output stt_pkg::cmp_res_t res
);

  logic in_range;
  logic above_cur;
  logic below_nxt;

  always_comb begin
    in_range  = ({1'b0, req.word_col} < req.matrix_cols) &&
                (32'(req.word_col) < stt_pkg::MAX_DIM);
    above_cur = !req.scan_mode || (req.word_col > req.cur_col);
    below_nxt = !req.nxt_found || (req.word_col < req.nxt_col);
    res.col_ok = in_range;
    res.match  = req.scan_mode && (req.word_col == req.cur_col);
    res.better = in_range && above_cur && below_nxt;
  end

endmodule

### rtl/stt_ctrl.sv
// Sequencer of the transpose unit: loads terms, runs the count pass and the
// column passes, and holds the output register. Depends on stt_pkg, stt_if and the macros header.
`timescale 1ns / 1ps
`include "sparse_triplet_transpose_unit_macros.svh"

module stt_ctrl #(
  parameter int MAX_TERMS = 32,
  parameter int AW        = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  stt_in_if.sink                      in_ch,
  stt_out_if.source                   out_ch,
  input  logic [stt_pkg::DIM_W-1:0]   matrix_rows,
  input  logic [stt_pkg::DIM_W-1:0]   matrix_cols,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output stt_pkg::term_word_t         mem_wdata,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_raddr,
  input  stt_pkg::term_word_t         mem_rdata,
  output stt_pkg::cmp_req_t           cmp_req,
  input  stt_pkg::cmp_res_t           cmp_res
);

  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam logic [CW-1:0] MaxTermsC = CW'(MAX_TERMS);

  stt_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]                count_r, count_nxt;
  logic [CW-1:0]                idx_r, idx_nxt;
  logic [CW-1:0]                total_r, total_nxt;
  logic [CW-1:0]                emitted_r, emitted_nxt;
  logic [stt_pkg::IDX_W-1:0]    cur_col_r, cur_col_nxt;
  logic [stt_pkg::IDX_W-1:0]    nxt_col_r, nxt_col_nxt;
  logic                         nxt_found_r, nxt_found_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [stt_pkg::DIM_W-1:0]    out_row_r, out_row_nxt;
  logic [stt_pkg::DIM_W-1:0]    out_col_r, out_col_nxt;
  logic [stt_pkg::VAL_W-1:0]    out_value_r, out_value_nxt;
  logic                         out_hdr_r, out_hdr_nxt;
  logic                         out_last_r, out_last_nxt;

  logic in_acc;
  logic can_load;
  logic at_end;
  logic last_hit;
  logic out_load;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign can_load = !out_valid_r || out_ch.ready;
  assign at_end   = (idx_r == count_r);
  assign last_hit = (CW'(emitted_r + 1'b1) == total_r);

  assign in_ch.ready        = (state_r == stt_pkg::ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_row     = out_row_r;
  assign out_ch.out_col     = out_col_r;
  assign out_ch.out_value   = out_value_r;
  assign out_ch.is_header   = out_hdr_r;
  assign out_ch.last_result = out_last_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      stt_pkg::ST_IDLE: begin
        if (in_acc && in_ch.last_term) begin
          state_nxt = stt_pkg::ST_CNT_RD;
        end
      end
      stt_pkg::ST_CNT_RD: begin
        state_nxt = at_end ? stt_pkg::ST_HDR : stt_pkg::ST_CNT_CHK;
      end
      stt_pkg::ST_CNT_CHK: begin
        state_nxt = stt_pkg::ST_CNT_RD;
      end
      stt_pkg::ST_HDR: begin
        if (can_load) begin
          state_nxt = (total_r == '0) ? stt_pkg::ST_IDLE : stt_pkg::ST_SCAN_RD;
        end
      end
      stt_pkg::ST_SCAN_RD: begin
        state_nxt = at_end ? stt_pkg::ST_PASS_END : stt_pkg::ST_SCAN_CHK;
      end
      stt_pkg::ST_SCAN_CHK: begin
        if (!cmp_res.match) begin
          state_nxt = stt_pkg::ST_SCAN_RD;
        end else if (can_load) begin
          state_nxt = last_hit ? stt_pkg::ST_IDLE : stt_pkg::ST_SCAN_RD;
        end
      end
      stt_pkg::ST_PASS_END: begin
        state_nxt = stt_pkg::ST_SCAN_RD;
      end
      default: begin
        state_nxt = stt_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    total_nxt     = total_r;
    emitted_nxt   = emitted_r;
    cur_col_nxt   = cur_col_r;
    nxt_col_nxt   = nxt_col_r;
    nxt_found_nxt = nxt_found_r;
    out_load      = 1'b0;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_value_nxt = out_value_r;
    out_hdr_nxt   = out_hdr_r;
    out_last_nxt  = out_last_r;

    mem_we          = in_acc && in_ch.has_term && (count_r < MaxTermsC);
    mem_waddr       = count_r[AW-1:0];
    mem_wdata.row   = in_ch.term_row;
    mem_wdata.col   = in_ch.term_col;
    mem_wdata.value = in_ch.term_value;
    mem_re          = ((state_r == stt_pkg::ST_CNT_RD) ||
                       (state_r == stt_pkg::ST_SCAN_RD)) && !at_end;
    mem_raddr       = idx_r[AW-1:0];

    cmp_req.word_col    = mem_rdata.col;
    cmp_req.cur_col     = cur_col_r;
    cmp_req.nxt_col     = nxt_col_r;
    cmp_req.nxt_found   = nxt_found_r;
    cmp_req.scan_mode   = (state_r == stt_pkg::ST_SCAN_CHK);
    cmp_req.matrix_cols = matrix_cols;

    case (state_r)
      stt_pkg::ST_IDLE: begin
        if (mem_we) begin
          count_nxt = CW'(count_r + 1'b1);
        end
        if (in_acc && in_ch.last_term) begin
          idx_nxt       = '0;
          total_nxt     = '0;
          nxt_found_nxt = 1'b0;
        end
      end
      stt_pkg::ST_CNT_CHK: begin
        if (cmp_res.col_ok) begin
          total_nxt = CW'(total_r + 1'b1);
        end
        if (cmp_res.better) begin
          nxt_col_nxt   = mem_rdata.col;
          nxt_found_nxt = 1'b1;
        end
        idx_nxt = CW'(idx_r + 1'b1);
      end
      stt_pkg::ST_HDR: begin
        if (can_load) begin
          out_load      = 1'b1;
          out_row_nxt   = matrix_cols;
          out_col_nxt   = matrix_rows;
          out_value_nxt = stt_pkg::VAL_W'(count_r);
          out_hdr_nxt   = 1'b1;
          out_last_nxt  = (total_r == '0);
          if (total_r == '0) begin
            count_nxt = '0;
          end else begin
            cur_col_nxt   = nxt_col_r;
            nxt_found_nxt = 1'b0;
            idx_nxt       = '0;
            emitted_nxt   = '0;
          end
        end
      end
      stt_pkg::ST_SCAN_CHK: begin
        if (!cmp_res.match || can_load) begin
          if (cmp_res.better) begin
            nxt_col_nxt   = mem_rdata.col;
            nxt_found_nxt = 1'b1;
          end
          idx_nxt = CW'(idx_r + 1'b1);
          if (cmp_res.match) begin
            out_load      = 1'b1;
            out_row_nxt   = {1'b0, cur_col_r};
            out_col_nxt   = {1'b0, mem_rdata.row};
            out_value_nxt = mem_rdata.value;
            out_hdr_nxt   = 1'b0;
            out_last_nxt  = last_hit;
            emitted_nxt   = CW'(emitted_r + 1'b1);
            if (last_hit) begin
              count_nxt = '0;
            end
          end
        end
      end
      stt_pkg::ST_PASS_END: begin
        cur_col_nxt   = nxt_col_r;
        nxt_found_nxt = 1'b0;
        idx_nxt       = '0;
      end
      default: begin
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stt_pkg::ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      total_r     <= '0;
      emitted_r   <= '0;
      nxt_found_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      total_r     <= total_nxt;
      emitted_r   <= emitted_nxt;
      nxt_found_r <= nxt_found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_col_r   <= cur_col_nxt;
    nxt_col_r   <= nxt_col_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_value_r <= out_value_nxt;
    out_hdr_r   <= out_hdr_nxt;
    out_last_r  <= out_last_nxt;
  end

  `STT_ASSERT_HOLDS(a_count_bound, clk, rst_n, 1'b1, count_r <= MaxTermsC, "term count overflow")
  `STT_ASSERT_HOLDS(a_total_bound, clk, rst_n, state_r != stt_pkg::ST_IDLE, total_r <= count_r, "scan total above term count")
  `STT_ASSERT_HOLDS(a_emit_bound, clk, rst_n, state_r == stt_pkg::ST_SCAN_CHK, emitted_r < total_r, "scan running past its last term")
  `STT_ASSERT_HOLDS(a_pass_has_next, clk, rst_n, state_r == stt_pkg::ST_PASS_END, nxt_found_r, "column pass ended with no next column")
  `STT_ASSERT_NEXT(a_done_clears, clk, rst_n, out_load && out_last_nxt, (count_r == '0) && (state_r == stt_pkg::ST_IDLE), "final result did not empty the store")

endmodule

### rtl/sparse_triplet_transpose_unit.sv
// Top level of the sparse triplet transpose unit: configuration registers and
// the sequencer, term store and compare unit. Depends on stt_pkg, stt_if,
// stt_term_mem, stt_col_cmp and stt_ctrl.
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Word contents
// in_ch     in   valid/ready          term_row, term_col, term_value, has_term, last_term
// out_ch    out  valid/ready          out_row, out_col, out_value, is_header, last_result
// cfg_*     in   cfg_we, no ready     cfg_idx selects matrix_rows or matrix_cols
//
// Words that do not close the matrix are taken one per cycle, back to back.
// A closing word starts the scan: a count pass over the stored terms, then the header,
// then one pass over the store per distinct in-range column, the last ending at its final match.
// The single store read port and the one shared compare unit pace the scan; output stalls hold it.
// Reset (rst_n low, synchronous) empties the store and sets both dimensions to 256.
// in_ch.ready is low during a scan; the next matrix may load while the last result waits.

module sparse_triplet_transpose_unit #(
  parameter int MAX_TERMS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  stt_in_if.sink                          in_ch,
  stt_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [stt_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [stt_pkg::DIM_W-1:0]       cfg_data
);

  // Term store address width; a single-entry store still gets one address bit.
  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  logic [stt_pkg::DIM_W-1:0] rows_r, rows_nxt;
  logic [stt_pkg::DIM_W-1:0] cols_r, cols_nxt;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  stt_pkg::term_word_t  mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  stt_pkg::term_word_t  mem_rdata;
  stt_pkg::cmp_req_t    cmp_req;
  stt_pkg::cmp_res_t    cmp_res;

  // Configuration writes; an index past the register list is dropped.
  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_we) begin
      case (cfg_idx)
        stt_pkg::REG_MATRIX_ROWS: rows_nxt = cfg_data;
        stt_pkg::REG_MATRIX_COLS: cols_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= stt_pkg::DIM_RESET;
      cols_r <= stt_pkg::DIM_RESET;
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
    end
  end

  // The store is only read below the fill count, so it needs no clearing.
  stt_term_mem #(
    .DEPTH (MAX_TERMS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // One compare unit serves both the counting pass and every column pass.
  stt_col_cmp u_cmp (
    .req (cmp_req),
    .res (cmp_res)
  );

  stt_ctrl #(
    .MAX_TERMS (MAX_TERMS),
    .AW        (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .matrix_rows (rows_r),
    .matrix_cols (cols_r),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .cmp_req     (cmp_req),
    .cmp_res     (cmp_res)
  );

endmodule

### dv/tb_sparse_triplet_transpose_unit.sv
// Self-checking testbench for the sparse triplet transpose unit: random and directed term
// words go in, transposed results are checked against an in-bench predictor.
// Depends on stt_pkg, stt_if and the sparse_triplet_transpose_unit RTL.
`timescale 1ns / 1ps

module tb_sparse_triplet_transpose_unit;

  localparam int MAX_TERMS = 32;
  // Settle time covers the worst scan: 32 column passes over a full store, rounded up.
  localparam int SCAN_SETTLE = 2500;
  localparam int LONG_HOLD_AFTER = 24;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam longint WATCHDOG_NS = 64'd12_000_000;

  // Indexes past the register list; writes to them must be ignored.
  localparam logic [stt_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [stt_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [stt_pkg::IDX_W-1:0] row;
    logic [stt_pkg::IDX_W-1:0] col;
    logic [stt_pkg::VAL_W-1:0] value;
    logic                      has_term;
    logic                      last_term;
  } term_item_t;

  typedef struct packed {
    logic [stt_pkg::DIM_W-1:0] row;
    logic [stt_pkg::DIM_W-1:0] col;
    logic [stt_pkg::VAL_W-1:0] value;
    logic                      is_header;
    logic                      last_result;
  } xpose_result_t;

  typedef enum int {COLS_ANY, COLS_CLUSTER, COLS_NEAR_LIMIT} col_pattern_t;
  typedef enum int {PACE_OPEN, PACE_HALF, PACE_SLOW, PACE_BUSY} pace_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                          cfg_we;
  logic [stt_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [stt_pkg::DIM_W-1:0]     cfg_data;

  stt_in_if  in_ch ();
  stt_out_if out_ch ();

  sparse_triplet_transpose_unit #(
    .MAX_TERMS(MAX_TERMS)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: the bench's own copy of the dimension registers and the term store.
  logic [stt_pkg::DIM_W-1:0] rows_cfg = stt_pkg::DIM_RESET;
  logic [stt_pkg::DIM_W-1:0] cols_cfg = stt_pkg::DIM_RESET;
  stt_pkg::term_word_t       held_terms[$];
  xpose_result_t             transposed_due[$];
  term_item_t                queued_words[$];

  int  queued_items = 0;
  int  words_in = 0;
  int  matrices_closed = 0;
  int  results_seen = 0;
  int  fail_cnt = 0;
  logic in_taken = 1'b0;

  // Sender and receiver pacing state.
  int  burst_left = 0;
  int  gap_left = 0;
  bit  offer;
  int  hold_left = 0;
  bit  long_hold_done = 1'b0;
  int  pace_left = 0;
  pace_t pace = PACE_OPEN;

  // Takes one accepted input word. A closing word produces the header and then the stored
  // terms in column order, arrival order within a column; columns outside the scan are
  // counted in the header but never sent.
  task automatic absorb_term_word(input term_item_t w);
    int unsigned         scan_lim;
    int unsigned         in_scan;
    int unsigned         sent;
    stt_pkg::term_word_t t;
    xpose_result_t       r;
    if (w.has_term && held_terms.size() < MAX_TERMS) begin
      t.row = w.row;
      t.col = w.col;
      t.value = w.value;
      held_terms.push_back(t);
    end
    if (!w.last_term) return;
    scan_lim = (cols_cfg > stt_pkg::MAX_DIM) ? stt_pkg::MAX_DIM : cols_cfg;
    in_scan = 0;
    foreach (held_terms[j]) if (held_terms[j].col < scan_lim) in_scan++;
    r.row = cols_cfg;
    r.col = rows_cfg;
    r.value = stt_pkg::VAL_W'(held_terms.size());
    r.is_header = 1'b1;
    r.last_result = (in_scan == 0);
    transposed_due.push_back(r);
    sent = 0;
    for (int unsigned c = 0; c < scan_lim && sent < in_scan; c++) begin
      foreach (held_terms[j]) begin
        if (held_terms[j].col == c) begin
          sent++;
          r.row = stt_pkg::DIM_W'(c);
          r.col = stt_pkg::DIM_W'(held_terms[j].row);
          r.value = held_terms[j].value;
          r.is_header = 1'b0;
          r.last_result = (sent == in_scan);
          transposed_due.push_back(r);
        end
      end
    end
    held_terms.delete();
    matrices_closed++;
  endtask

  task automatic check_result();
    xpose_result_t want;
    results_seen++;
    if (transposed_due.size() == 0) begin
      $error("result word with nothing expected: row %0d col %0d value %0d",
             out_ch.out_row, out_ch.out_col, out_ch.out_value);
      fail_cnt++;
      return;
    end
    want = transposed_due.pop_front();
    if (out_ch.out_row !== want.row) begin
      $error("out_row: expected %0d, got %0d", want.row, out_ch.out_row);
      fail_cnt++;
    end
    if (out_ch.out_col !== want.col) begin
      $error("out_col: expected %0d, got %0d", want.col, out_ch.out_col);
      fail_cnt++;
    end
    if (out_ch.out_value !== want.value) begin
      $error("out_value: expected %0d, got %0d", $signed(want.value), out_ch.out_value);
      fail_cnt++;
    end
    if (out_ch.is_header !== want.is_header) begin
      $error("is_header: expected %0b, got %0b", want.is_header, out_ch.is_header);
      fail_cnt++;
    end
    if (out_ch.last_result !== want.last_result) begin
      $error("last_result: expected %0b, got %0b", want.last_result, out_ch.last_result);
      fail_cnt++;
    end
  endtask

  // Monitor: both channels are sampled at the rising edge. The result check runs before the
  // input word is absorbed, so a result accepted at this edge only meets older expectations.
  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (in_ch.valid && in_ch.ready) begin
        words_in++;
        absorb_term_word({in_ch.term_row, in_ch.term_col, in_ch.term_value,
                          in_ch.has_term, in_ch.last_term});
      end
    end
  end

  // Driver: offers queued words in bursts of random length separated by random gaps.
  // A word stays on the bus until the edge that accepts it.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) void'(queued_words.pop_front());
      if (!in_ch.valid || in_taken) begin
        offer = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (queued_words.size() != 0) begin
          offer = 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 24);
          burst_left--;
          if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        in_ch.valid <= offer;
        if (offer) begin
          in_ch.term_row   <= queued_words[0].row;
          in_ch.term_col   <= queued_words[0].col;
          in_ch.term_value <= queued_words[0].value;
          in_ch.has_term   <= queued_words[0].has_term;
          in_ch.last_term  <= queued_words[0].last_term;
        end
      end
    end
  end

  // Receiver: switches between random paces. Once, partway into the run, it holds off
  // for a long stretch while the sender keeps going, so the output register fills, the scan
  // stalls and the input channel backs up.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!long_hold_done && words_in >= LONG_HOLD_AFTER) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else begin
      if (pace_left == 0) begin
        pace = pace_t'($urandom_range(0, 3));
        pace_left = $urandom_range(8, 64);
      end
      pace_left--;
      case (pace)
        PACE_OPEN: out_ch.ready <= 1'b1;
        PACE_HALF: out_ch.ready <= 1'($urandom_range(0, 1));
        PACE_SLOW: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:   out_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic push_word(input logic [stt_pkg::IDX_W-1:0] row,
                           input logic [stt_pkg::IDX_W-1:0] col,
                           input logic [stt_pkg::VAL_W-1:0] value, input bit has,
                           input bit last);
    queued_words.push_back('{row: row, col: col, value: value, has_term: has,
                             last_term: last});
    if (has || last) queued_items++;
  endtask

  // Registers change only with the block idle, so the model can follow at once.
  task automatic write_reg(input logic [stt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [stt_pkg::DIM_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == stt_pkg::REG_MATRIX_ROWS) rows_cfg = data;
    else if (idx == stt_pkg::REG_MATRIX_COLS) cols_cfg = data;
  endtask

  // Sender pause: nothing left to send and every expected result in, then the scan settle
  // time, since an ignored word or the tail of a scan may still be in flight.
  task automatic wait_idle();
    while (queued_words.size() != 0 || in_ch.valid || transposed_due.size() != 0)
      @(posedge clk);
    repeat (SCAN_SETTLE) @(posedge clk);
  endtask

  // One random matrix of n_terms terms. Columns are either anywhere, clustered so that a
  // column holds several terms, or spread up to just past the scan limit.
  task automatic gen_matrix(input int n_terms);
    int           lim;
    int           cap;
    int           base;
    int           pick;
    bit           close_on_term;
    col_pattern_t pattern;
    logic [stt_pkg::IDX_W-1:0] c;
    lim = (cols_cfg > stt_pkg::MAX_DIM) ? stt_pkg::MAX_DIM : cols_cfg;
    cap = (lim + 2 > 255) ? 255 : lim + 2;
    base = $urandom_range(0, cap);
    pattern = col_pattern_t'($urandom_range(0, 2));
    close_on_term = 1'($urandom_range(0, 1));
    for (int i = 0; i < n_terms; i++) begin
      if ($urandom_range(0, 15) == 0) push_word(8'($urandom), 8'($urandom),
                                                 16'($urandom), 1'b0, 1'b0);
      case (pattern)
        COLS_ANY: c = 8'($urandom_range(0, 255));
        COLS_CLUSTER: begin
          pick = base + $urandom_range(0, 2);
          c = (pick > 255) ? 8'd255 : 8'(pick);
        end
        default: c = 8'($urandom_range(0, cap));
      endcase
      push_word(8'($urandom), c, 16'($urandom), 1'b1, close_on_term && (i == n_terms - 1));
    end
    // An empty matrix, or one closed by a bare end marker.
    if (n_terms == 0 || !close_on_term) push_word(8'($urandom), 8'($urandom),
                                                  16'($urandom), 1'b0, 1'b1);
  endtask

  // Mostly small matrices; now and then a medium one or one that fills or overfills the store.
  task automatic run_random_phase(input int quota);
    int start;
    int r;
    start = queued_items;
    while (queued_items - start < quota) begin
      r = $urandom_range(0, 19);
      if (r == 0) gen_matrix(0);
      else if (r <= 15) gen_matrix($urandom_range(1, 6));
      else if (r <= 18) gen_matrix($urandom_range(7, 20));
      else gen_matrix($urandom_range(MAX_TERMS, MAX_TERMS + 4));
    end
    wait_idle();
  endtask

  initial begin
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.term_row = '0;
    in_ch.term_col = '0;
    in_ch.term_value = '0;
    in_ch.has_term = 1'b0;
    in_ch.last_term = 1'b0;
    out_ch.ready = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Reset dimensions. Field extremes, an ignored word mid-matrix and a term on the
    // closing word; then an empty matrix, then a matrix closed by a bare end marker.
    push_word(8'd0, 8'd0, 16'h8000, 1'b1, 1'b0);
    push_word(8'd255, 8'd255, 16'h7FFF, 1'b1, 1'b0);
    push_word(8'hFF, 8'hFF, 16'hFFFF, 1'b0, 1'b0);
    push_word(8'd128, 8'd255, 16'hFFFF, 1'b1, 1'b0);
    push_word(8'd7, 8'd0, 16'h0001, 1'b1, 1'b1);
    push_word(8'hAA, 8'h55, 16'h1234, 1'b0, 1'b1);
    push_word(8'd5, 8'd9, 16'd100, 1'b1, 1'b0);
    push_word(8'd6, 8'd9, 16'hFF9C, 1'b1, 1'b0);
    push_word(8'd0, 8'd0, 16'h0000, 1'b0, 1'b1);
    wait_idle();

    // One by one: columns past the first are counted but not sent, and a matrix whose
    // terms all fall outside the scan puts last_result on the header.
    write_reg(stt_pkg::REG_MATRIX_ROWS, 9'd1);
    write_reg(stt_pkg::REG_MATRIX_COLS, 9'd1);
    push_word(8'd0, 8'd0, 16'd11, 1'b1, 1'b0);
    push_word(8'd0, 8'd1, 16'd22, 1'b1, 1'b0);
    push_word(8'd0, 8'd200, 16'd33, 1'b1, 1'b1);
    push_word(8'd3, 8'd5, 16'd9, 1'b1, 1'b1);
    wait_idle();

    // Zero dimensions are out of range: the header reports them and the scan sends nothing.
    // Writes past the register list must leave both registers alone.
    write_reg(stt_pkg::REG_MATRIX_ROWS, 9'd0);
    write_reg(stt_pkg::REG_MATRIX_COLS, 9'd0);
    write_reg(REG_SPARE_2, 9'h1FF);
    write_reg(REG_SPARE_3, 9'h1FF);
    push_word(8'd1, 8'd0, 16'd5, 1'b1, 1'b0);
    push_word(8'd2, 8'd3, 16'd6, 1'b1, 1'b1);
    wait_idle();

    // Random phases over several dimension settings; the first starts with a store overflow.
    write_reg(stt_pkg::REG_MATRIX_ROWS, 9'd255);
    write_reg(stt_pkg::REG_MATRIX_COLS, 9'd256);
    gen_matrix(MAX_TERMS + 4);
    run_random_phase(8);

    write_reg(stt_pkg::REG_MATRIX_ROWS, 9'h1FF);
    write_reg(stt_pkg::REG_MATRIX_COLS, 9'd300);
    run_random_phase(8);

    write_reg(stt_pkg::REG_MATRIX_ROWS, 9'd17);
    write_reg(stt_pkg::REG_MATRIX_COLS, 9'd16);
    run_random_phase(8);

    write_reg(stt_pkg::REG_MATRIX_ROWS, 9'($urandom_range(1, 256)));
    write_reg(stt_pkg::REG_MATRIX_COLS, 9'($urandom_range(1, 256)));
    write_reg(REG_SPARE_2, 9'($urandom));
    write_reg(REG_SPARE_3, 9'($urandom));
    run_random_phase(8);

    write_reg(stt_pkg::REG_MATRIX_ROWS, 9'd256);
    write_reg(stt_pkg::REG_MATRIX_COLS, 9'd2);
    run_random_phase(8);

    $display("Run summary: %0d input words closed %0d matrices, %0d result words checked,",
             words_in, matrices_closed, results_seen);
    $display("  across zero, one, full-size and oversized dimensions with one long output hold.");
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
